### hdl/imlp_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imlp_pkg
// Shared types and character constants for the IRC line parser.
// ----------------------------------------------------------------------------
package imlp_pkg;

  // Characters the parser reacts to
  localparam logic [7:0] CH_CR    = 8'd13;
  localparam logic [7:0] CH_LF    = 8'd10;
  localparam logic [7:0] CH_COLON = 8'd58;
  localparam logic [7:0] CH_SPACE = 8'd32;

  // Digits in a numeric command
  localparam logic [1:0] NUMERIC_LEN = 2'd3;

  localparam logic [7:0] PARAM_MAX = 8'd255;

  // Role of a byte
  typedef enum logic [2:0] {
    K_CMD   = 3'd0,
    K_PARAM = 3'd1,
    K_TRAIL = 3'd2,
    K_DROP  = 3'd3,
    K_CR    = 3'd4,
    K_DONE  = 3'd5,
    K_ERR   = 3'd6
  } kind_t;

  // Error report codes
  typedef enum logic [2:0] {
    E_NONE     = 3'd0,
    E_BAD_CMD  = 3'd1,
    E_SHORT_NUM = 3'd2,
    E_AFTER_SP = 3'd3,
    E_NO_CR    = 3'd4,
    E_NO_LF    = 3'd5,
    E_END      = 3'd6
  } err_t;

  // Parse phase, one-hot
  typedef enum logic [10:0] {
    PH_CMD_START   = 11'b000_0000_0001,
    PH_LETTERS     = 11'b000_0000_0010,
    PH_DIGITS      = 11'b000_0000_0100,
    PH_AFTER_CMD   = 11'b000_0000_1000,
    PH_SPACES      = 11'b000_0001_0000,
    PH_MID         = 11'b000_0010_0000,
    PH_MID_COLON   = 11'b000_0100_0000,
    PH_TRAIL_START = 11'b000_1000_0000,
    PH_TRAIL       = 11'b001_0000_0000,
    PH_GOT_CR      = 11'b010_0000_0000,
    PH_DROP        = 11'b100_0000_0000
  } phase_t;

  // Decision for one byte
  typedef struct packed {
    kind_t  kind;
    err_t   err;
    logic   start;
    logic   open;   // open a new parameter
    phase_t phase;
    logic   nl;     // restart line after this byte
  } step_t;

endpackage : imlp_pkg
`default_nettype wire

### hdl/irc_message_line_parser_unit.sv
`default_nettype none
// ----------------------------------------------------------------------------
// irc_message_line_parser_unit
// Byte-stream parser for IRC-style lines; tags every byte with its role.
// ----------------------------------------------------------------------------
//
//  channel | ports                                   | direction | flow
//  --------+-----------------------------------------+-----------+-----------
//  in      | in_valid in_stall in_byte_value in_is_end| sink      | 1 byte/clk
//  out     | out_valid out_stall out_kind out_char_out| source    | 1 item/clk
//          | out_starts_field out_param_index        |           |
//          | out_error_code                          |           |
//
//  One result per byte, one byte per cycle sustained while the output is not
//  stalled. An input transfer loads the input register; the byte then moves
//  into the result register once that is free or draining, and the result
//  is on the output from there. The per-byte decision is one pass through the
//  phase decoder and the parameter counter incrementer.
//  rst_n (synchronous, active low) empties both registers and puts the parser
//  at the start of a line. A stall on the output holds the result register;
//  in_stall is high whenever the input register holds a byte behind it.
// ----------------------------------------------------------------------------
module irc_message_line_parser_unit
  import imlp_pkg::*;
(
  input  wire logic       clk,
  input  wire logic       rst_n,
  // input channel
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] in_byte_value,
  input  wire logic       in_is_end,
  // result channel
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic [2:0]      out_kind,
  output logic [7:0]      out_char_out,
  output logic            out_starts_field,
  output logic [7:0]      out_param_index,
  output logic [2:0]      out_error_code
);

  // --------------------------------------------------------------------------
  // Input register
  // --------------------------------------------------------------------------
  logic       in_vld_r, in_vld_nxt;
  logic [7:0] byte_r;
  logic       end_r;

  // Parse state
  phase_t     phase_r, phase_nxt;
  logic [1:0] dig_r, dig_nxt;
  logic [7:0] cnt_r, cnt_nxt;
  logic       lws_r, lws_nxt;

  // Result register
  logic       out_vld_r, out_vld_nxt;
  kind_t      kind_r;
  logic [7:0] char_r;
  logic       start_r;
  logic [7:0] pidx_r;
  err_t       err_r;

  logic       advance;    // the held byte moves into the result register
  logic       in_accept;

  // Move when there is a byte and the result slot is free or draining
  assign advance   = in_vld_r && (!out_vld_r || !out_stall);
  assign in_stall  = in_vld_r && !advance;
  assign in_accept = in_valid && !in_stall;

  // --------------------------------------------------------------------------
  // Byte classes
  // --------------------------------------------------------------------------
  logic is_alpha, is_digit, is_word;

  always_comb begin
    is_alpha = byte_r inside {[8'd65:8'd90], [8'd97:8'd122]};
    is_digit = byte_r inside {[8'd48:8'd57]};
    is_word  = !(byte_r inside {CH_CR, CH_LF, CH_COLON, CH_SPACE});
  end

  // Report an error; an LF restarts the line at once, else drop to LF
  function automatic step_t fail_step(input logic [7:0] b, input err_t code);
    step_t s;
    s = '{kind: K_ERR, err: code, start: 1'b0, open: 1'b0,
          phase: PH_DROP, nl: (b == CH_LF)};
    return s;
  endfunction

  // End of a field: a space run, CR, or a missing CR
  function automatic step_t after_step(input logic [7:0] b);
    step_t s;
    if (b == CH_SPACE) begin
      s = '{kind: K_DROP, err: E_NONE, start: 1'b0, open: 1'b0,
            phase: PH_SPACES, nl: 1'b0};
    end else if (b == CH_CR) begin
      s = '{kind: K_CR, err: E_NONE, start: 1'b0, open: 1'b0,
            phase: PH_GOT_CR, nl: 1'b0};
    end else begin
      s = fail_step(b, E_NO_CR);
    end
    return s;
  endfunction

  // --------------------------------------------------------------------------
  // Phase decoder
  // --------------------------------------------------------------------------
  step_t      st;
  logic [1:0] dig_step;
  logic       lws_step;

  always_comb begin
    st = '{kind: K_DROP, err: E_NONE, start: 1'b0, open: 1'b0,
           phase: phase_r, nl: 1'b0};
    dig_step = dig_r;
    lws_step = lws_r;
    if (end_r) begin
      // end of text: report and restart from any phase
      st = '{kind: K_ERR, err: E_END, start: 1'b0, open: 1'b0,
             phase: PH_CMD_START, nl: 1'b1};
    end else begin
      case (phase_r)
        PH_CMD_START: begin
          if (is_alpha) begin
            st = '{kind: K_CMD, err: E_NONE, start: 1'b1, open: 1'b0,
                   phase: PH_LETTERS, nl: 1'b0};
          end else if (is_digit) begin
            st = '{kind: K_CMD, err: E_NONE, start: 1'b1, open: 1'b0,
                   phase: PH_DIGITS, nl: 1'b0};
            dig_step = 2'd1;
          end else begin
            st = fail_step(byte_r, E_BAD_CMD);
          end
        end
        PH_LETTERS: begin
          if (is_alpha) begin
            st.kind = K_CMD;
          end else begin
            st = after_step(byte_r);
          end
        end
        PH_DIGITS: begin
          if (is_digit) begin
            st.kind = K_CMD;
            dig_step = dig_r + 2'd1;
            if (dig_step >= NUMERIC_LEN) begin
              dig_step = 2'd0;
              st.phase = PH_AFTER_CMD;
            end
          end else begin
            st = fail_step(byte_r, E_SHORT_NUM);
          end
        end
        PH_AFTER_CMD: begin
          st = after_step(byte_r);
        end
        PH_SPACES: begin
          if (byte_r == CH_SPACE) begin
            st.kind = K_DROP;
          end else if (byte_r == CH_COLON) begin
            st.phase = PH_TRAIL_START;
          end else if (byte_r == CH_CR || byte_r == CH_LF) begin
            st = fail_step(byte_r, E_AFTER_SP);
          end else begin
            st = '{kind: K_PARAM, err: E_NONE, start: 1'b1, open: 1'b1,
                   phase: PH_MID, nl: 1'b0};
          end
        end
        PH_MID, PH_MID_COLON: begin
          if (byte_r == CH_COLON) begin
            st.phase = PH_MID_COLON;
          end else if (is_word) begin
            st.kind  = K_PARAM;
            st.start = (phase_r == PH_MID_COLON);
            st.open  = (phase_r == PH_MID_COLON);
            st.phase = PH_MID;
          end else begin
            st = after_step(byte_r);
          end
        end
        PH_TRAIL_START, PH_TRAIL: begin
          if (byte_r == CH_CR || byte_r == CH_LF) begin
            st = after_step(byte_r);
          end else if (phase_r == PH_TRAIL_START) begin
            st = '{kind: K_TRAIL, err: E_NONE, start: 1'b1, open: 1'b1,
                   phase: PH_TRAIL, nl: 1'b0};
            lws_step = (byte_r == CH_SPACE);
          end else if (byte_r == CH_SPACE && lws_r) begin
            st.kind = K_DROP;   // collapse space run
          end else begin
            st.kind  = K_TRAIL;
            lws_step = (byte_r == CH_SPACE);
          end
        end
        PH_GOT_CR: begin
          if (byte_r == CH_LF) begin
            st.kind = K_DONE;
            st.nl   = 1'b1;
          end else begin
            st = fail_step(byte_r, E_NO_LF);
          end
        end
        default: begin
          // dropping after an error, up to and including LF
          st.kind = K_DROP;
          st.nl   = (byte_r == CH_LF);
        end
      endcase
    end
  end

  // Counter after this byte; line restart clears state for the next byte
  logic [7:0] cnt_after;

  always_comb begin
    cnt_after = (st.open && cnt_r != PARAM_MAX) ? cnt_r + 8'd1 : cnt_r;
    if (st.nl) begin
      phase_nxt = PH_CMD_START;
      dig_nxt   = 2'd0;
      cnt_nxt   = 8'd0;
      lws_nxt   = 1'b0;
    end else begin
      phase_nxt = st.phase;
      dig_nxt   = dig_step;
      cnt_nxt   = cnt_after;
      lws_nxt   = lws_step;
    end
  end

  // Valid flags of the two registers
  always_comb begin
    in_vld_nxt = in_vld_r;
    if (in_accept) begin
      in_vld_nxt = 1'b1;
    end else if (advance) begin
      in_vld_nxt = 1'b0;
    end
    out_vld_nxt = out_vld_r;
    if (advance) begin
      out_vld_nxt = 1'b1;
    end else if (!out_stall) begin
      out_vld_nxt = 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Registers
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      phase_r   <= PH_CMD_START;
      dig_r     <= 2'd0;
      cnt_r     <= 8'd0;
      lws_r     <= 1'b0;
    end else begin
      in_vld_r  <= in_vld_nxt;
      out_vld_r <= out_vld_nxt;
      if (advance) begin
        phase_r <= phase_nxt;
        dig_r   <= dig_nxt;
        cnt_r   <= cnt_nxt;
        lws_r   <= lws_nxt;
      end
    end
  end

  // Payload: capture on transfer, hold otherwise
  always_ff @(posedge clk) begin
    if (in_accept) begin
      byte_r <= in_byte_value;
      end_r  <= in_is_end;
    end
    if (advance) begin
      kind_r  <= st.kind;
      char_r  <= end_r ? 8'd0 : byte_r;
      start_r <= st.start;
      pidx_r  <= cnt_after;
      err_r   <= st.err;
    end
  end

  assign out_valid        = out_vld_r;
  assign out_kind         = kind_r;
  assign out_char_out     = char_r;
  assign out_starts_field = start_r;
  assign out_param_index  = pidx_r;
  assign out_error_code   = err_r;

endmodule : irc_message_line_parser_unit
`default_nettype wire

### hdl/imlp_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// imlp_checker
// Port-level checks for the IRC line parser, bound to the top level.
// ----------------------------------------------------------------------------
module imlp_checker
  import imlp_pkg::*;
(
  input wire logic       clk,
  input wire logic       rst_n,
  input wire logic       in_stall,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic [2:0] out_kind,
  input wire logic [7:0] out_char_out,
  input wire logic       out_starts_field,
  input wire logic [7:0] out_param_index,
  input wire logic [2:0] out_error_code
);

  // Stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_kind) &&
      $stable(out_char_out) && $stable(out_param_index) && $stable(out_error_code))
    else $error("stalled result changed");

  // Error code only rides with an error report
  a_err_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind != K_ERR |-> out_error_code == E_NONE)
    else $error("error code without error kind");

  // Command bytes belong to no parameter
  a_cmd_index: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_CMD |-> out_param_index == 8'd0)
    else $error("command byte with nonzero parameter index");

  // Line done is always an LF and never opens a field
  a_done_lf: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_kind == K_DONE |-> out_char_out == CH_LF && !out_starts_field)
    else $error("line done on a byte other than LF");

  // Input backs up only behind a stalled result
  a_in_stall: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid && out_stall)
    else $error("input stalled with the result side free");

endmodule : imlp_checker

bind irc_message_line_parser_unit imlp_checker u_imlp_checker (.*);
`default_nettype wire
